@@ rtl/nexp_pkg.sv @@
// Shared constants, types and constant tables of the negative exponential block.
package nexp_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int TAYLOR_TERMS = 8;
    localparam int POWER_STEPS  = 5;

    localparam int ARG_W  = 32;
    localparam int EXP_W  = 33;
    localparam int X_W    = 31;
    localparam int MAX_TERMS = 12;

    // One cell per Horner step, at least one per table step
    localparam int NUM_CELLS = (TAYLOR_TERMS - 1 > POWER_STEPS) ? TAYLOR_TERMS - 1 : POWER_STEPS;

    localparam logic [EXP_W-1:0] Q_ONE           = 33'h1_0000_0000;
    localparam logic [31:0]      E_MINUS_ONE_Q32 = 32'd1580030208;

    // floor(2^32 / i!) for i = 0 .. MAX_TERMS-1
    localparam logic [EXP_W-1:0] HORNER_COEF [MAX_TERMS] = '{
        33'd4294967296, 33'd4294967296, 33'd2147483648, 33'd715827882,
        33'd178956970,  33'd35791394,   33'd5965232,    33'd852176,
        33'd106522,     33'd11835,      33'd1183,       33'd107
    };

    // Data handed from cell to cell
    typedef struct packed {
        logic [EXP_W-1:0]       v;
        logic [X_W-1:0]         x;
        logic [EXP_W-1:0]       major;
        logic [POWER_STEPS-1:0] ibits;
        logic                   underflow;
    } t_cell_data;

    // e^-(2^k) in Q32, each entry the truncated square of the one before
    function automatic logic [31:0] tab_const(input int k);
        logic [63:0] t;
        t = 64'(E_MINUS_ONE_Q32);
        for (int j = 0; j < k; j++) begin
            t = (t * t) >> 32;
        end
        return t[31:0];
    endfunction

endpackage

@@ rtl/nexp_if.sv @@
// Valid/ready channel interfaces for the input and result items.
interface nexp_in_if;
    logic                          valid;
    logic                          ready;
    logic [nexp_pkg::ARG_W-1:0]    arg_magnitude;

    modport source (output valid, output arg_magnitude, input ready);
    modport sink   (input valid, input arg_magnitude, output ready);
endinterface

interface nexp_out_if;
    logic                          valid;
    logic                          ready;
    logic [nexp_pkg::EXP_W-1:0]    exp_value;
    logic                          underflow;

    modport source (output valid, output exp_value, output underflow, input ready);
    modport sink   (input valid, input exp_value, input underflow, output ready);
endinterface

@@ rtl/nexp_cell.sv @@
// One chain cell: a Horner step of the series and a table step of the integer part.
module nexp_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  nexp_pkg::t_cell_data         i_data,
    output logic                         o_ready,
    output logic                         o_valid,
    output nexp_pkg::t_cell_data         o_data,
    input  logic                         i_ready,
    input  logic [nexp_pkg::EXP_W-1:0]   i_coef,
    input  logic [31:0]                  i_tab,
    input  logic                         i_horner_en,
    input  logic                         i_tab_en
);

    logic                  r_valid;
    nexp_pkg::t_cell_data  r_data;
    nexp_pkg::t_cell_data  n_data;
    logic [63:0]           w_hprod;
    logic [31:0]           w_p;
    logic [64:0]           w_tprod;

    // Take a new item whenever this cell is empty or its item moves on
    assign o_ready = !r_valid || i_ready;

    assign w_hprod = {31'd0, i_data.v} * {33'd0, i_data.x};
    assign w_p     = w_hprod[63:32];
    assign w_tprod = {32'd0, i_data.major} * {33'd0, i_tab};

    // Form the step results
    always_comb begin
        n_data = i_data;
        if (i_horner_en) begin
            n_data.v = ({1'b0, w_p} > i_coef) ? '0 : i_coef - {1'b0, w_p};
        end
        if (i_tab_en) begin
            if (i_data.ibits[0]) begin
                n_data.major = w_tprod[64:32];
            end
            n_data.ibits = i_data.ibits >> 1;
        end
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/nexp_tail.sv @@
// Tail of the chain: square the series value, then scale by the table product.
module nexp_tail (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  nexp_pkg::t_cell_data         i_data,
    output logic                         o_ready,
    output logic                         o_valid,
    output logic [nexp_pkg::EXP_W-1:0]   o_exp_value,
    output logic                         o_underflow,
    input  logic                         i_ready
);

    logic                        r_sq_valid;
    logic [nexp_pkg::EXP_W-1:0]  r_sq;
    logic [nexp_pkg::EXP_W-1:0]  r_major;
    logic                        r_sq_uf;
    logic                        w_sq_ready;
    logic [65:0]                 w_sq_prod;

    logic                        r_res_valid;
    logic [nexp_pkg::EXP_W-1:0]  r_res;
    logic                        r_res_uf;
    logic                        w_res_ready;
    logic [65:0]                 w_res_prod;

    assign w_res_ready = !r_res_valid || i_ready;
    assign w_sq_ready  = !r_sq_valid || w_res_ready;
    assign o_ready     = w_sq_ready;

    assign w_sq_prod  = {33'd0, i_data.v} * {33'd0, i_data.v};
    assign w_res_prod = {33'd0, r_sq} * {33'd0, r_major};

    // Advance valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_sq_ready) begin
                r_sq_valid <= i_valid;
            end
            if (w_res_ready) begin
                r_res_valid <= r_sq_valid;
            end
        end
    end

    // Square the series value
    always_ff @(posedge i_clk) begin
        if (w_sq_ready && i_valid) begin
            r_sq    <= w_sq_prod[64:32];
            r_major <= i_data.major;
            r_sq_uf <= i_data.underflow;
        end
    end

    // Scale by the table product and hold for the sink
    always_ff @(posedge i_clk) begin
        if (w_res_ready && r_sq_valid) begin
            r_res    <= w_res_prod[64:32];
            r_res_uf <= r_sq_uf;
        end
    end

    assign o_valid     = r_res_valid;
    assign o_exp_value = r_res;
    assign o_underflow = r_res_uf;

endmodule

@@ rtl/negative_exp_table_taylor.sv @@
// Top level of the negative exponential: entry logic, cell chain and output tail.
// Each item passes one register per cell, then the square and result registers of the tail.
// Throughput: one item per cycle while the sink is ready; every cell and tail stage holds one item.
// The depth follows from one multiplier per cell for Horner and one for the table.
// Stalled stages fill bubbles, so items are taken while a result waits.
// Reset (i_rst_n low, synchronous) empties all stages; the data registers themselves are not reset.
module negative_exp_table_taylor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nexp_in_if.sink      i_arg,
    nexp_out_if.source   o_res
);

    localparam int NC = nexp_pkg::NUM_CELLS;

    logic                  w_valid [NC+1];
    logic                  w_ready [NC+1];
    nexp_pkg::t_cell_data  w_data  [NC+1];
    nexp_pkg::t_cell_data  w_seed;

    logic [31:0]           w_ipart;
    logic [31:0]           w_frac;
    logic [31:0]           w_xw;
    logic                  w_uf;

    // Split the magnitude into integer part and Q32 fraction, and flag underflow
    assign w_ipart = i_arg.arg_magnitude >> nexp_pkg::FRAC_BITS;
    assign w_frac  = i_arg.arg_magnitude
                     & 32'((64'd1 << nexp_pkg::FRAC_BITS) - 64'd1);
    assign w_xw    = w_frac << (32 - nexp_pkg::FRAC_BITS);
    assign w_uf    = w_ipart >= (32'd1 << nexp_pkg::POWER_STEPS);

    // Seed the chain
    always_comb begin
        w_seed.v         = nexp_pkg::HORNER_COEF[nexp_pkg::TAYLOR_TERMS-1];
        w_seed.x         = w_xw[31:1];
        w_seed.major     = w_uf ? '0 : nexp_pkg::Q_ONE;
        w_seed.ibits     = w_ipart[nexp_pkg::POWER_STEPS-1:0];
        w_seed.underflow = w_uf;
    end

    assign w_data[0]   = w_seed;
    assign w_valid[0]  = i_arg.valid;
    assign i_arg.ready = w_ready[0];

    // Build the cell chain
    for (genvar k = 0; k < NC; k++) begin : g_cell
        localparam bit HEN = (k < nexp_pkg::TAYLOR_TERMS - 1);
        localparam bit TEN = (k < nexp_pkg::POWER_STEPS);
        localparam logic [nexp_pkg::EXP_W-1:0] COEF =
            HEN ? nexp_pkg::HORNER_COEF[HEN ? nexp_pkg::TAYLOR_TERMS - 2 - k : 0] : '0;
        localparam logic [31:0] TAB = TEN ? nexp_pkg::tab_const(k) : 32'd0;

        nexp_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_valid[k]),
            .i_data      (w_data[k]),
            .o_ready     (w_ready[k]),
            .o_valid     (w_valid[k+1]),
            .o_data      (w_data[k+1]),
            .i_ready     (w_ready[k+1]),
            .i_coef      (COEF),
            .i_tab       (TAB),
            .i_horner_en (HEN),
            .i_tab_en    (TEN)
        );
    end

    // Square, scale and present the result
    nexp_tail u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[NC]),
        .i_data      (w_data[NC]),
        .o_ready     (w_ready[NC]),
        .o_valid     (o_res.valid),
        .o_exp_value (o_res.exp_value),
        .o_underflow (o_res.underflow),
        .i_ready     (o_res.ready)
    );

`ifndef ASSERT_OFF
    a_uf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.underflow |-> o_res.exp_value == '0)
        else $error("underflow result is not zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.exp_value <= nexp_pkg::Q_ONE)
        else $error("result above 1.0");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.ready |-> i_arg.ready)
        else $error("input stalled while output side is ready");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule

@@ sim/negative_exp_table_taylor_tb.sv @@
// Self-checking testbench for the negative exponential block: directed edge values and random streams.
module negative_exp_table_taylor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] E_NEG_ONE_Q32 = 64'd1580030208;
    localparam logic [63:0] Q32_ONE       = 64'd1 << 32;
    localparam int          SETTLE_CYCLES = 4 * (nexp_pkg::NUM_CELLS + 2);
    localparam int          MAX_SHOWN     = 10;

    typedef struct packed {
        logic [nexp_pkg::ARG_W-1:0] arg;
        logic [nexp_pkg::EXP_W-1:0] exp_value;
        logic                       underflow;
    } t_exp_result;

    logic i_clk;
    logic i_rst_n;

    nexp_in_if  arg_ch ();
    nexp_out_if res_ch ();

    negative_exp_table_taylor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_arg   (arg_ch),
        .o_res   (res_ch)
    );

    t_exp_result pending_results[$];

    bit steady_flow;
    int burst_left;
    int items_sent;
    int underflow_sent;
    int results_checked;
    int mismatch_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Truncated Q32 product, operands up to 1.0
    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        logic [65:0] p;
        p = 66'(a) * 66'(b);
        return 64'(p >> 32);
    endfunction

    // Expected e^-a: table product of the integer bits times the squared half-fraction series
    function automatic t_exp_result predict_neg_exp(input logic [nexp_pkg::ARG_W-1:0] arg);
        logic [63:0]  int_part;
        logic [63:0]  frac;
        logic [63:0]  x_half;
        logic [63:0]  tab;
        logic [63:0]  major;
        logic [63:0]  root;
        logic [63:0]  fact;
        logic [63:0]  p;
        logic [63:0]  coef[nexp_pkg::TAYLOR_TERMS];
        t_exp_result  res;
        int_part = 64'(arg) >> nexp_pkg::FRAC_BITS;
        frac = 64'(arg) & ((64'd1 << nexp_pkg::FRAC_BITS) - 64'd1);
        res.arg = arg;
        res.exp_value = '0;
        res.underflow = 1'b0;
        if (int_part >= (64'd1 << nexp_pkg::POWER_STEPS)) begin
            res.underflow = 1'b1;
            return res;
        end
        // Multiply in e^-(2^k) for every set integer bit
        tab = E_NEG_ONE_Q32;
        major = Q32_ONE;
        for (int k = 0; k < nexp_pkg::POWER_STEPS; k++) begin
            if (int_part[k]) major = q32_mul(major, tab);
            tab = (tab * tab) >> 32;
        end
        // Horner over floor(2^32 / i!) with X = r/2
        fact = 64'd1;
        for (int i = 0; i < nexp_pkg::TAYLOR_TERMS; i++) begin
            if (i > 1) fact = fact * 64'(i);
            coef[i] = Q32_ONE / fact;
        end
        x_half = (frac << (32 - nexp_pkg::FRAC_BITS)) >> 1;
        root = coef[nexp_pkg::TAYLOR_TERMS-1];
        for (int i = nexp_pkg::TAYLOR_TERMS - 2; i >= 0; i--) begin
            p = (root * x_half) >> 32;
            root = (p > coef[i]) ? 64'd0 : coef[i] - p;
        end
        res.exp_value = nexp_pkg::EXP_W'(q32_mul(q32_mul(root, root), major));
        return res;
    endfunction

    // Offer one item, honoring the burst/gap pattern, and record its expected result
    task automatic send_arg(input logic [nexp_pkg::ARG_W-1:0] arg);
        t_exp_result expected;
        if (!steady_flow && burst_left <= 0) begin
            arg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        arg_ch.valid <= 1'b1;
        arg_ch.arg_magnitude <= arg;
        @(posedge i_clk);
        while (!arg_ch.ready) @(posedge i_clk);
        expected = predict_neg_exp(arg);
        pending_results.push_back(expected);
        items_sent++;
        if (expected.underflow) underflow_sent++;
        burst_left--;
    endtask

    // Zero, the underflow boundary, the top of the range and single fraction bits
    task automatic test_special_values();
        logic [63:0] boundary;
        boundary = 64'd32 << nexp_pkg::FRAC_BITS;
        send_arg('0);
        send_arg('1);
        send_arg(nexp_pkg::ARG_W'(boundary));
        send_arg(nexp_pkg::ARG_W'(boundary - 64'd1));
        send_arg(nexp_pkg::ARG_W'(1));
        send_arg(nexp_pkg::ARG_W'((64'd1 << nexp_pkg::FRAC_BITS) - 64'd1));
        send_arg(nexp_pkg::ARG_W'(64'd1 << (nexp_pkg::FRAC_BITS - 1)));
        send_arg({1'b1, {(nexp_pkg::ARG_W-1){1'b0}}});
    endtask

    // Each table constant alone, with zero and with full fraction, then all integer bits together
    task automatic test_power_steps();
        logic [63:0] frac_max;
        frac_max = (64'd1 << nexp_pkg::FRAC_BITS) - 64'd1;
        for (int k = 0; k < nexp_pkg::POWER_STEPS; k++) begin
            send_arg(nexp_pkg::ARG_W'(64'd1 << (nexp_pkg::FRAC_BITS + k)));
            send_arg(nexp_pkg::ARG_W'((64'd1 << (nexp_pkg::FRAC_BITS + k)) | frac_max));
        end
        send_arg(nexp_pkg::ARG_W'(64'd31 << nexp_pkg::FRAC_BITS));
    endtask

    // Magnitudes below the underflow limit, where the arithmetic is exercised
    task automatic test_random_in_range(input int count);
        logic [63:0] top;
        top = (64'd32 << nexp_pkg::FRAC_BITS) - 64'd1;
        if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                // small integer part, random fraction
                send_arg(nexp_pkg::ARG_W'(($urandom_range(0, 3) << nexp_pkg::FRAC_BITS) |
                         ($urandom() & ((64'd1 << nexp_pkg::FRAC_BITS) - 64'd1))));
            end else begin
                send_arg(nexp_pkg::ARG_W'($urandom_range(0, 32'(top))));
            end
        end
    endtask

    // Any 32-bit pattern, mostly underflow
    task automatic test_random_full_range(input int count);
        repeat (count) send_arg(nexp_pkg::ARG_W'($urandom()));
    endtask

    // Back-to-back items with the receiver always ready
    task automatic test_steady_stream(input int count);
        steady_flow = 1'b1;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) send_arg(nexp_pkg::ARG_W'($urandom()));
            else send_arg(nexp_pkg::ARG_W'($urandom_range(0,
                          32'((64'd32 << nexp_pkg::FRAC_BITS) - 64'd1))));
        end
        steady_flow = 1'b0;
    endtask

    // Check each result and drive the receiver's stall pattern
    int ready_run;
    always @(posedge i_clk) begin
        t_exp_result expected;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result exp_value=%h underflow=%b",
                             res_ch.exp_value, res_ch.underflow);
            end else begin
                expected = pending_results.pop_front();
                if (res_ch.exp_value !== expected.exp_value ||
                    res_ch.underflow !== expected.underflow) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("mismatch arg=%h: exp_value exp %h got %h, underflow exp %b got %b",
                                 expected.arg, expected.exp_value, res_ch.exp_value,
                                 expected.underflow, res_ch.underflow);
                end
            end
        end
        // Hold the receiver idle in reset, then alternate ready and stall runs
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            ready_run = 0;
        end else if (steady_flow) begin
            res_ch.ready <= 1'b1;
            ready_run = 0;
        end else if (ready_run <= 0) begin
            res_ch.ready <= ~res_ch.ready;
            ready_run = res_ch.ready ? $urandom_range(1, 12) : $urandom_range(1, 16);
        end else begin
            ready_run--;
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence
    initial begin
        steady_flow = 1'b0;
        burst_left = 0;
        items_sent = 0;
        underflow_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        i_rst_n <= 1'b0;
        arg_ch.valid <= 1'b0;
        arg_ch.arg_magnitude <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_values();
        test_power_steps();
        test_random_in_range(700);
        test_random_full_range(300);
        test_steady_stream(150);

        // Drain and let any stray result show up
        arg_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d magnitudes (%0d past the underflow limit), checked %0d results.",
                 items_sent, underflow_sent, results_checked);
        $display("Mismatches or stray results: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/nexp_pkg.sv
rtl/nexp_if.sv
rtl/nexp_cell.sv
rtl/nexp_tail.sv
rtl/negative_exp_table_taylor.sv
sim/negative_exp_table_taylor_tb.sv
